FILE: design/histogram_bin_counter_macros.svh
// Assertion macros for the histogram bin counter checker.
// Used by hbc_checker; no other dependencies.
`ifndef HISTOGRAM_BIN_COUNTER_MACROS_SVH
`define HISTOGRAM_BIN_COUNTER_MACROS_SVH

// Check a property while reset is low.
`define HBC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("histogram bin counter check failed");

// Check a property on every clock edge, reset included.
`define HBC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("histogram bin counter check failed");

`endif

FILE: design/hbc_pkg.sv
// Shared types and constants for the histogram bin counter.
// No dependencies; compiled first.
package hbc_pkg;

   // Bins addressable by the 6-bit edge and bin index fields
   localparam int MAX_BINS = 64;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // Command codes
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_DUMP  = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   // Configuration register indexes
   localparam logic REG_BIN_COUNT  = 1'b0;
   localparam logic REG_CUMULATIVE = 1'b1;

   // Transaction travelling down the cell chain
   typedef struct packed {
      logic               valid;
      logic [1:0]         command;
      logic [5:0]         edge_index;
      logic signed [63:0] value;
      logic               found;
   } token_type;

   // Dump shift control, common to all cells
   typedef struct packed {
      logic snapshot;
      logic shift;
   } dump_ctl_type;

endpackage

FILE: design/hbc_if.sv
// Valid/ready channel interfaces for the histogram bin counter.
// Depends on nothing but the language; payload widths are fixed.
interface hbc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [5:0]         edge_index;
   logic signed [63:0] value;

   modport source (output valid, command, edge_index, value, input ready);
   modport sink   (input valid, command, edge_index, value, output ready);
endinterface

interface hbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  bin_index;
   logic [31:0] count;
   logic        last;

   modport source (output valid, bin_index, count, last, input ready);
   modport sink   (input valid, bin_index, count, last, output ready);
endinterface

FILE: design/hbc_cell.sv
// One bin of the histogram: lower edge, saturating count and dump stage.
// Depends on hbc_pkg for the token and dump control types.
module hbc_cell #(
   parameter int CELL_ID = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [6:0]           bins_in_use,
   input  hbc_pkg::token_type    token_in,
   output hbc_pkg::token_type    token_out,
   input  hbc_pkg::dump_ctl_type dump_ctl,
   input  logic [31:0]          dump_in,
   output logic [31:0]          dump_out
);
   import hbc_pkg::*;

   localparam logic [5:0] ID_CODE  = 6'(CELL_ID);
   localparam logic [6:0] ID_WIDE  = 7'(CELL_ID);
   localparam logic       IS_FIRST = (CELL_ID == 0);

   logic signed [63:0] edge_ff, edge_in;
   logic [31:0]        count_ff, count_in;
   logic [31:0]        dump_ff, dump_in_next;
   token_type          token_ff, token_in_next;
   logic               active, is_sample, hit;

   // Bin 0 takes every sample that no higher bin claimed
   always_comb begin
      active    = ID_WIDE < bins_in_use;
      is_sample = token_in.valid && (token_in.command == CMD_SAMPLE);
      hit       = is_sample && !token_in.found && active &&
                  (IS_FIRST || (edge_ff <= token_in.value));
   end

   // Update edge and count for the transaction passing this cell
   always_comb begin
      edge_in  = edge_ff;
      count_in = count_ff;
      if (token_in.valid && (token_in.command == CMD_LOAD) &&
          (token_in.edge_index == ID_CODE)) begin
         edge_in = token_in.value;
      end
      priority if (token_in.valid && (token_in.command == CMD_CLEAR)) begin
         count_in = '0;
      end else if (hit && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + 32'd1;
      end
      token_in_next       = token_in;
      token_in_next.found = token_in.found | hit;
   end

   // Capture counts for a dump, then shift them towards bin 0
   always_comb begin
      dump_in_next = dump_ff;
      priority if (dump_ctl.snapshot) begin
         dump_in_next = count_ff;
      end else if (dump_ctl.shift) begin
         dump_in_next = dump_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         token_ff <= '0;
      end else begin
         count_ff <= count_in;
         token_ff <= token_in_next;
      end
   end

   // Edges stay undefined until loaded
   always_ff @(posedge clock) begin
      edge_ff <= edge_in;
      dump_ff <= dump_in_next;
   end

   assign token_out = token_ff;
   assign dump_out  = dump_ff;

endmodule

FILE: design/histogram_bin_counter.sv
// Histogram bin counter: a chain of bin cells with a dump sequencer.
// Depends on hbc_pkg, hbc_req_if / hbc_rsp_if and hbc_cell.
//
// Usage:
//   req_chan carries command, edge_index and value. Load, sample and clear
//   transactions are taken one per cycle outside a dump and travel the cell
//   chain from the highest bin down to bin 0, one cell per cycle; the first
//   cell in use whose edge is at or below a sample counts it, bin 0 catching
//   the rest. A dump stops intake and itself walks the chain; once the chain
//   has drained, every count is copied into the dump stages, then one bin per
//   cycle shifts to rsp_chan, bin 0 first, as plain or saturating cumulative
//   counts; last marks the final bin in use.
//   rsp_chan has an output register: a stalled receiver holds the current
//   transaction and freezes the shift; once the last bin is loaded intake
//   resumes even while it waits. csr_* writes bin_count (index 0) and
//   cumulative_mode (index 1), to be done while idle.
//   Synchronous reset clears all counts, sets bin_count to 64 and
//   cumulative_mode to 0; edges are undefined until loaded.
module histogram_bin_counter #(
   parameter int BIN_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [6:0]  csr_write_data,
   hbc_req_if.sink     req_chan,
   hbc_rsp_if.source   rsp_chan
);
   import hbc_pkg::*;

   localparam int         NUM_CELLS   = (BIN_DEPTH < MAX_BINS) ? BIN_DEPTH : MAX_BINS;
   localparam logic [6:0] CELLS_LIMIT = 7'(NUM_CELLS);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DRAIN = 3'b010,
      ST_SEND  = 3'b100
   } dump_state_type;

   dump_state_type state_ff, state_in;
   logic [6:0]     bin_count_ff, bin_count_in;
   logic           cumulative_ff, cumulative_in;
   logic [6:0]     bins_in_use;
   logic [5:0]     send_idx_ff, send_idx_in;
   logic [31:0]    run_ff, run_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [5:0]     rsp_bin_ff, rsp_bin_in;
   logic [31:0]    rsp_count_ff, rsp_count_in;
   logic           rsp_last_ff, rsp_last_in;

   token_type      token_link [NUM_CELLS+1];
   logic [31:0]    dump_link  [NUM_CELLS+1];
   logic [NUM_CELLS-1:0] busy_vec;
   dump_ctl_type   dump_ctl;
   logic           req_accept, chain_busy, slot_free, send_last;
   logic [32:0]    run_sum;
   logic [31:0]    run_sat;

   // Configuration registers
   always_comb begin
      bin_count_in  = bin_count_ff;
      cumulative_in = cumulative_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_BIN_COUNT:  bin_count_in  = csr_write_data;
            REG_CUMULATIVE: cumulative_in = csr_write_data[0];
            default:        ;
         endcase
      end
   end

   // Clamp bins in use to 1 .. cells available
   always_comb begin
      priority if (bin_count_ff == 7'd0) begin
         bins_in_use = 7'd1;
      end else if (bin_count_ff > CELLS_LIMIT) begin
         bins_in_use = CELLS_LIMIT;
      end else begin
         bins_in_use = bin_count_ff;
      end
   end

   // Feed accepted transactions into the top of the chain
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      token_link[NUM_CELLS].valid      = req_accept;
      token_link[NUM_CELLS].command    = req_chan.command;
      token_link[NUM_CELLS].edge_index = req_chan.edge_index;
      token_link[NUM_CELLS].value      = req_chan.value;
      token_link[NUM_CELLS].found      = 1'b0;
   end
   assign dump_link[NUM_CELLS] = '0;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      hbc_cell #(
         .CELL_ID (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .bins_in_use (bins_in_use),
         .token_in    (token_link[g+1]),
         .token_out   (token_link[g]),
         .dump_ctl    (dump_ctl),
         .dump_in     (dump_link[g+1]),
         .dump_out    (dump_link[g])
      );
      assign busy_vec[g] = token_link[g].valid;
   end

   assign chain_busy = |busy_vec;
   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;
   assign send_last  = (7'(send_idx_ff) + 7'd1) == bins_in_use;
   assign run_sum    = {1'b0, run_ff} + {1'b0, dump_link[0]};
   assign run_sat    = run_sum[32] ? COUNT_MAX : run_sum[31:0];

   // Dump sequencer: drain, snapshot, shift out
   always_comb begin
      state_in          = state_ff;
      send_idx_in       = send_idx_ff;
      run_in            = run_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_bin_in        = rsp_bin_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_last_in       = rsp_last_ff;
      dump_ctl.snapshot = 1'b0;
      dump_ctl.shift    = 1'b0;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_chan.command == CMD_DUMP)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!chain_busy) begin
               dump_ctl.snapshot = 1'b1;
               send_idx_in       = '0;
               run_in            = '0;
               state_in          = ST_SEND;
            end
         end
         ST_SEND: begin
            if (slot_free) begin
               dump_ctl.shift = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_bin_in     = send_idx_ff;
               rsp_count_in   = cumulative_ff ? run_sat : dump_link[0];
               rsp_last_in    = send_last;
               run_in         = run_sat;
               send_idx_in    = send_idx_ff + 6'd1;
               if (send_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bin_count_ff  <= 7'd64;
         cumulative_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bin_count_ff  <= bin_count_in;
         cumulative_ff <= cumulative_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      send_idx_ff  <= send_idx_in;
      run_ff       <= run_in;
      rsp_bin_ff   <= rsp_bin_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.bin_index = rsp_bin_ff;
   assign rsp_chan.count     = rsp_count_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule

FILE: design/hbc_checker.sv
// Port-level checks for the histogram bin counter, bound to the top level.
// Depends on histogram_bin_counter_macros.svh.
`include "histogram_bin_counter_macros.svh"

module hbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_bin_index,
   input logic [31:0] rsp_count,
   input logic        rsp_last
);

   logic        rsp_stall;
   logic [38:0] rsp_payload;

   // View the result side as one word, and flag a stalled transaction
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_bin_index, rsp_count, rsp_last};

   // Hold a stalled result transaction
   `HBC_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_payload))

   // Drop any result after reset
   `HBC_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid)

   // Block intake while a dump is still shifting out
   `HBC_ASSERT(a_dump_blocks, clock, reset, rsp_valid && !rsp_last |-> !req_ready)

   // The highest bin is always the end of a dump
   `HBC_ASSERT(a_top_is_last, clock, reset, rsp_valid && (rsp_bin_index == 6'd63) |-> rsp_last)

endmodule

bind histogram_bin_counter hbc_checker u_hbc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_bin_index (rsp_chan.bin_index),
   .rsp_count     (rsp_chan.count),
   .rsp_last      (rsp_chan.last)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for histogram_bin_counter: loads bin edges, streams samples, dumps
// and clears, predicting every dumped bin and checking it as it arrives.
// Depends on hbc_pkg, hbc_req_if / hbc_rsp_if and the histogram_bin_counter RTL.
module tb;
   import hbc_pkg::*;

   // Chain drain plus margin; also the quiet time before a register write
   localparam int SETTLE_CYCLES = MAX_BINS + 16;
   localparam logic [63:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MINUS_ONE     = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum int {EDGES_LINEAR, EDGES_LOG, EDGES_SPAN, EDGES_UNORDERED} edge_style_type;

   typedef struct {
      logic [5:0]  bin_index;
      logic [31:0] count;
      logic        last;
   } bin_report_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic       csr_index;
   logic [6:0] csr_write_data;

   hbc_req_if req_chan ();
   hbc_rsp_if rsp_chan ();

   // Predicted histogram state
   logic signed [63:0] lower_edges [MAX_BINS];
   bit                 edge_loaded [MAX_BINS];
   logic [31:0]        bin_tally [MAX_BINS];
   logic [6:0]         bin_count_reg;
   logic               cumulative_reg;
   bin_report_type     expected_reports [$];

   int mismatches    = 0;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   histogram_bin_counter #(.BIN_DEPTH(MAX_BINS)) uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the receiver at random
   always @(negedge clock) begin
      rsp_chan.ready = ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   function automatic int active_bins();
      int n;
      n = bin_count_reg;
      if (n < 1) n = 1;
      if (n > MAX_BINS) n = MAX_BINS;
      return n;
   endfunction

   // Advance the predicted histogram by one accepted transaction
   task automatic apply_to_histogram(logic [1:0] cmd, logic [5:0] idx,
                                     logic signed [63:0] val);
      int             n;
      int             hit;
      logic [32:0]    running;
      logic [31:0]    tally;
      bin_report_type report_item;
      n = active_bins();
      case (cmd)
         CMD_LOAD: begin
            lower_edges[idx] = val;
            edge_loaded[idx] = 1'b1;
         end
         CMD_SAMPLE: begin
            hit = 0;
            for (int i = 0; i < n; i++)
               if (lower_edges[i] <= val) hit = i;
            if (bin_tally[hit] != COUNT_MAX) bin_tally[hit]++;
         end
         CMD_CLEAR: begin
            foreach (bin_tally[i]) bin_tally[i] = '0;
         end
         default: begin
            running = '0;
            for (int i = 0; i < n; i++) begin
               tally = bin_tally[i];
               if (cumulative_reg) begin
                  running = running + tally;
                  if (running > COUNT_MAX) running = {1'b0, COUNT_MAX};
                  tally = running[31:0];
               end
               report_item.bin_index = 6'(i);
               report_item.count     = tally;
               report_item.last      = (i == n - 1);
               expected_reports.push_back(report_item);
            end
         end
      endcase
   endtask

   // Compare each accepted bin report with the oldest prediction
   always @(posedge clock) begin : check_reports
      bin_report_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("unpredicted bin report", rsp_chan.bin_index, 0);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_chan.bin_index !== want.bin_index)
               report_mismatch("bin_index", rsp_chan.bin_index, want.bin_index);
            if (rsp_chan.count !== want.count)
               report_mismatch("count", rsp_chan.count, want.count);
            if (rsp_chan.last !== want.last)
               report_mismatch("last", rsp_chan.last, want.last);
         end
      end
   end

   // Drive one transaction, idling first at random, and hold it until taken
   task automatic send_item(logic [1:0] cmd, logic [5:0] idx, logic signed [63:0] val);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.command    = cmd;
      req_chan.edge_index = idx;
      req_chan.value      = val;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      apply_to_histogram(cmd, idx, val);
      items_sent++;
   endtask

   // Drop valid, wait for every predicted report, then let the chain drain
   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [6:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (idx == REG_BIN_COUNT) bin_count_reg = data;
      else cumulative_reg = data[0];
   endtask

   // Load edges 0 to n-1 in one of several layouts
   task automatic load_edge_set(int n);
      edge_style_type style;
      logic [63:0]    base;
      logic [63:0]    step;
      logic [63:0]    span_step;
      logic [63:0]    edge_value;
      int             shift_off;
      style     = edge_style_type'($urandom_range(3));
      base      = {$urandom, $urandom};
      base      = {{23{base[40]}}, base[40:0]};
      step      = 64'($urandom) + 64'd1;
      span_step = MINUS_ONE / n;
      shift_off = $urandom_range(64 - n);
      for (int i = 0; i < n; i++) begin
         case (style)
            EDGES_LINEAR: edge_value = base + 64'(i) * step;
            EDGES_LOG:    edge_value = (i == 0) ? 64'd0 : (64'd1 << (i - 1 + shift_off));
            EDGES_SPAN:   edge_value = (64'(i) * span_step) ^ MOST_NEGATIVE;
            default:      edge_value = {$urandom, $urandom};
         endcase
         send_item(CMD_LOAD, 6'(i), edge_value);
      end
   endtask

   // Mostly land on or next to an edge in use; sometimes anywhere
   function automatic logic [63:0] pick_sample(int n);
      int          pick;
      logic [63:0] anchor;
      pick   = $urandom_range(9);
      anchor = lower_edges[$urandom_range(n - 1)];
      case (pick)
         0:       return {$urandom, $urandom};
         1:       return MOST_NEGATIVE;
         2:       return MOST_POSITIVE;
         3:       return anchor - 64'd1;
         4:       return anchor - 64'($urandom_range(1 << 20));
         5, 6:    return anchor;
         default: return anchor + 64'($urandom_range(1 << 20));
      endcase
   endfunction

   // One histogram pass: optional new settings, edges if needed, samples, dump
   task automatic run_random_round(bit reconfigure);
      int n;
      int pick;
      int samples;
      bit need_edges;
      if (reconfigure) begin
         wait_idle();
         pick = $urandom_range(19);
         case (pick)
            0:       write_csr(REG_BIN_COUNT, 7'd1);
            1:       write_csr(REG_BIN_COUNT, 7'd64);
            2:       write_csr(REG_BIN_COUNT, 7'd0);
            3:       write_csr(REG_BIN_COUNT, 7'($urandom_range(65, 127)));
            4, 5, 6: write_csr(REG_BIN_COUNT, 7'($urandom_range(17, 63)));
            default: write_csr(REG_BIN_COUNT, 7'($urandom_range(2, 16)));
         endcase
         write_csr(REG_CUMULATIVE, 7'($urandom));
      end
      n = active_bins();
      need_edges = ($urandom_range(3) == 0);
      for (int i = 0; i < n; i++)
         if (!edge_loaded[i]) need_edges = 1'b1;
      if (need_edges) load_edge_set(n);
      if ($urandom_range(3) == 0) send_item(CMD_CLEAR, 6'($urandom), {$urandom, $urandom});
      samples = $urandom_range(1, 16);
      repeat (samples) begin
         pick = $urandom_range(19);
         if (pick == 0)
            send_item(CMD_DUMP, 6'($urandom), {$urandom, $urandom});
         else if (pick == 1)
            send_item(CMD_CLEAR, 6'($urandom), {$urandom, $urandom});
         else if (pick == 2)
            send_item(CMD_LOAD, 6'($urandom_range(n - 1)), {$urandom, $urandom});
         else
            send_item(CMD_SAMPLE, 6'($urandom), pick_sample(n));
      end
      send_item(CMD_DUMP, 6'($urandom), {$urandom, $urandom});
   endtask

   // All 64 bins zero with the settings from reset
   task automatic test_reset_state();
      send_item(CMD_DUMP, 6'd0, 64'd0);
   endtask

   // Edge at the signed minimum; samples at both extremes, on and beside edges
   task automatic test_edge_extremes();
      wait_idle();
      write_csr(REG_BIN_COUNT, 7'd4);
      write_csr(REG_CUMULATIVE, 7'd0);
      send_item(CMD_LOAD, 6'd0, MOST_NEGATIVE);
      send_item(CMD_LOAD, 6'd1, MINUS_ONE);
      send_item(CMD_LOAD, 6'd2, 64'd0);
      send_item(CMD_LOAD, 6'd3, 64'h0000_0001_0000_0000);
      send_item(CMD_SAMPLE, 6'd63, MOST_POSITIVE);
      send_item(CMD_SAMPLE, 6'd0, MOST_NEGATIVE);
      send_item(CMD_SAMPLE, 6'd0, 64'hFFFF_FFFF_FFFF_FFFE);
      send_item(CMD_SAMPLE, 6'd0, MINUS_ONE);
      send_item(CMD_SAMPLE, 6'd0, 64'd0);
      send_item(CMD_SAMPLE, 6'd0, 64'h0000_0000_FFFF_FFFF);
      send_item(CMD_SAMPLE, 6'd0, 64'h0000_0001_0000_0000);
      send_item(CMD_DUMP, 6'd0, 64'd0);
   endtask

   // Running sums, then a clear that keeps the edges
   task automatic test_cumulative_and_clear();
      wait_idle();
      write_csr(REG_CUMULATIVE, 7'd1);
      send_item(CMD_DUMP, 6'd0, 64'd0);
      send_item(CMD_CLEAR, 6'd0, 64'd0);
      send_item(CMD_SAMPLE, 6'd0, MOST_POSITIVE);
      send_item(CMD_DUMP, 6'd0, 64'd0);
      wait_idle();
      // only bit 0 of the data counts for this register
      write_csr(REG_CUMULATIVE, 7'h7E);
   endtask

   // A bin count of zero acts as one; above 64 it clamps to 64
   task automatic test_bin_count_limits();
      wait_idle();
      write_csr(REG_BIN_COUNT, 7'd0);
      send_item(CMD_SAMPLE, 6'd0, MOST_POSITIVE);
      send_item(CMD_DUMP, 6'd0, 64'd0);
      wait_idle();
      write_csr(REG_BIN_COUNT, 7'd127);
      send_item(CMD_DUMP, 6'd0, 64'd0);
   endtask

   // Edges out of order: highest qualifying bin wins, else bin 0
   task automatic test_unordered_edges();
      wait_idle();
      write_csr(REG_BIN_COUNT, 7'd3);
      send_item(CMD_LOAD, 6'd0, 64'sd100);
      send_item(CMD_LOAD, 6'd1, -64'sd100);
      send_item(CMD_LOAD, 6'd2, 64'sd50);
      send_item(CMD_SAMPLE, 6'd0, 64'sd75);
      send_item(CMD_SAMPLE, 6'd0, 64'sd0);
      send_item(CMD_SAMPLE, 6'd0, -64'sd200);
      send_item(CMD_DUMP, 6'd0, 64'd0);
   endtask

   task automatic test_random_traffic(int sender_pct, int receiver_pct, int budget);
      int target;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      target = items_sent + budget;
      run_random_round(1'b1);
      while (items_sent < target) run_random_round($urandom_range(2) == 0);
   endtask

   initial begin
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_index           = REG_BIN_COUNT;
      csr_write_data      = '0;
      req_chan.valid      = 1'b0;
      req_chan.command    = CMD_LOAD;
      req_chan.edge_index = '0;
      req_chan.value      = '0;
      rsp_chan.ready      = 1'b0;
      bin_count_reg       = 7'd64;
      cumulative_reg      = 1'b0;
      foreach (bin_tally[i]) begin
         bin_tally[i]   = '0;
         edge_loaded[i] = 1'b0;
         lower_edges[i] = '0;
      end
      send_idle_pct = 29;
      recv_idle_pct = 52;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_edge_extremes();
      test_cumulative_and_clear();
      test_bin_count_limits();
      test_unordered_edges();
      test_random_traffic(29, 52, 95);
      test_random_traffic(52, 29, 95);
      test_random_traffic(0, 0, 95);

      wait_idle();
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
